// ----- src/rlbe_pkg.sv -----
// Shared constants for the resistor-ladder keypad event detector.
`default_nettype none

package rlbe_pkg;

   // Fixed field widths
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned CLASS_W     = 3;
   localparam int unsigned EVENT_W     = 3;
   localparam int unsigned COUNT_W     = 2;
   localparam int unsigned HOLD_W      = 16;
   localparam int unsigned LIMIT_W     = 2;
   localparam int unsigned MAX_BUTTONS = 4;
   localparam int unsigned BTN_IDX_W   = 2;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned STATE_W     = 3;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_RANGE1   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_RANGE2   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_RANGE3   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_RANGE4   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_DEBOUNCE = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_GAP      = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_LONG     = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_LIMIT    = 3'd7;

   // Machine states
   localparam logic [STATE_W-1:0] ST_IDLE     = 3'd0;
   localparam logic [STATE_W-1:0] ST_DOWN     = 3'd1;
   localparam logic [STATE_W-1:0] ST_UP       = 3'd2;
   localparam logic [STATE_W-1:0] ST_COUNT    = 3'd3;
   localparam logic [STATE_W-1:0] ST_LONG     = 3'd4;
   localparam logic [STATE_W-1:0] ST_LONG_END = 3'd5;

   // Event codes
   localparam logic [EVENT_W-1:0] EV_NONE        = 3'd0;
   localparam logic [EVENT_W-1:0] EV_CLICK       = 3'd1;
   localparam logic [EVENT_W-1:0] EV_DOUBLE      = 3'd2;
   localparam logic [EVENT_W-1:0] EV_LONG_START  = 3'd3;
   localparam logic [EVENT_W-1:0] EV_LONG_DURING = 3'd4;
   localparam logic [EVENT_W-1:0] EV_LONG_STOP   = 3'd5;

   // Reset timing values
   localparam logic [HOLD_W-1:0]  DEBOUNCE_RST = 16'd50;
   localparam logic [HOLD_W-1:0]  GAP_RST      = 16'd400;
   localparam logic [HOLD_W-1:0]  LONG_RST     = 16'd800;
   localparam logic [LIMIT_W-1:0] LIMIT_RST    = 2'd1;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 2'd3;

   typedef logic [COUNT_W-1:0] count_type;

endpackage

`default_nettype wire

// ----- src/resistor_ladder_button_events_top.sv -----
// Keypad ladder classifier, debouncer and click / long-press event machine.
//
//  Channel  | Ports                      | Content
//  ---------+----------------------------+---------------------------------------
//  request  | req_tvalid/tready/tdata    | adc_sample, time_ms
//  response | rsp_tvalid/tready/tdata    | event_code, event_button (one per req)
//  control  | csr_we/csr_addr/csr_wdata  | window, timing and click-limit writes
//
// One request per cycle sustained while the response is not stalled; each request
// passes the input register, then the result register. The classify, debounce and
// state update run in one pass between them. Synchronous reset restores default
// windows and timings and idles the machine. A stalled response holds the result
// register; the input register keeps taking requests until both stages are full.
`default_nettype none

module resistor_ladder_button_events_top #(
   parameter int unsigned BUTTONS  = 4,
   parameter int unsigned ADC_BITS = 10
) (
   input  wire logic clock,
   input  wire logic reset,
   // request
   input  wire logic req_tvalid,
   output logic      req_tready,
   // [ADC_BITS-1:0] adc_sample, [ADC_BITS+31:ADC_BITS] time_ms, zero pad
   input  wire logic [((ADC_BITS+32+7)/8)*8-1:0] req_tdata,
   // response
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // [2:0] event_code, [5:3] event_button, [7:6] zero
   output logic [7:0] rsp_tdata,
   // control
   input  wire logic csr_we,
   input  wire logic [rlbe_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [((2*ADC_BITS > 16) ? 2*ADC_BITS : 16)-1:0] csr_wdata
);
   import rlbe_pkg::*;

   localparam int unsigned RANGE_W = 2 * ADC_BITS;

   // Default windows: 0..100, 150..300, 350..550, 600..800
   localparam logic [RANGE_W-1:0] RANGE1_RST = {ADC_BITS'(100), ADC_BITS'(0)};
   localparam logic [RANGE_W-1:0] RANGE2_RST = {ADC_BITS'(300), ADC_BITS'(150)};
   localparam logic [RANGE_W-1:0] RANGE3_RST = {ADC_BITS'(550), ADC_BITS'(350)};
   localparam logic [RANGE_W-1:0] RANGE4_RST = {ADC_BITS'(800), ADC_BITS'(600)};

   // Configuration registers
   logic [RANGE_W-1:0] range_ff [MAX_BUTTONS];
   logic [HOLD_W-1:0]  debounce_ff;
   logic [HOLD_W-1:0]  gap_ff;
   logic [HOLD_W-1:0]  long_ff;
   logic [LIMIT_W-1:0] limit_ff;

   // Pipeline registers
   logic                in_valid_ff;
   logic [ADC_BITS-1:0] sample_ff;
   logic [TIME_W-1:0]   now_ff;
   logic                rsp_valid_ff;
   logic [EVENT_W-1:0]  code_ff,   code_in;
   logic [CLASS_W-1:0]  button_ff, button_in;

   // Detector state
   logic [CLASS_W-1:0] cand_ff,    cand_in;
   logic [TIME_W-1:0]  change_ff,  change_in;
   logic [CLASS_W-1:0] deb_ff,     deb_in;
   logic [STATE_W-1:0] state_ff,   state_in;
   logic [TIME_W-1:0]  phase_ff,   phase_in;
   logic [CLASS_W-1:0] latched_ff, latched_in;
   count_type          counts_ff [MAX_BUTTONS];
   count_type          counts_in [MAX_BUTTONS];

   logic out_free;
   logic advance;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, button_ff, code_ff};

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff[0] <= RANGE1_RST;
         range_ff[1] <= RANGE2_RST;
         range_ff[2] <= RANGE3_RST;
         range_ff[3] <= RANGE4_RST;
         debounce_ff <= DEBOUNCE_RST;
         gap_ff      <= GAP_RST;
         long_ff     <= LONG_RST;
         limit_ff    <= LIMIT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_RANGE1:   range_ff[0] <= csr_wdata[RANGE_W-1:0];
            REG_RANGE2:   range_ff[1] <= csr_wdata[RANGE_W-1:0];
            REG_RANGE3:   range_ff[2] <= csr_wdata[RANGE_W-1:0];
            REG_RANGE4:   range_ff[3] <= csr_wdata[RANGE_W-1:0];
            REG_DEBOUNCE: debounce_ff <= csr_wdata[HOLD_W-1:0];
            REG_GAP:      gap_ff      <= csr_wdata[HOLD_W-1:0];
            REG_LONG:     long_ff     <= csr_wdata[HOLD_W-1:0];
            REG_LIMIT:    limit_ff    <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         sample_ff <= req_tdata[ADC_BITS-1:0];
         now_ff    <= req_tdata[ADC_BITS+TIME_W-1:ADC_BITS];
      end
   end

   // Classify: lowest-numbered matching window wins
   logic [CLASS_W-1:0] cls;
   always_comb begin
      cls = '0;
      for (int b = BUTTONS - 1; b >= 0; b--) begin
         if (sample_ff >= range_ff[b][ADC_BITS-1:0] &&
             sample_ff <= range_ff[b][RANGE_W-1:ADC_BITS]) begin
            cls = CLASS_W'(b + 1);
         end
      end
   end

   // Debounce and event machine
   logic [TIME_W-1:0]    since_change;
   logic [TIME_W-1:0]    wait_ms;
   logic                 active;
   logic                 has_btn;
   logic [BTN_IDX_W-1:0] idx;
   count_type            n;
   logic                 seq_end;
   logic [EVENT_W-1:0]   ev;

   always_comb begin
      since_change = now_ff - change_ff;
      wait_ms      = now_ff - phase_ff;
      has_btn      = latched_ff != '0;
      idx          = latched_ff[BTN_IDX_W-1:0] - BTN_IDX_W'(1);
      n            = has_btn ? counts_ff[idx] : '0;

      cand_in   = cand_ff;
      change_in = change_ff;
      deb_in    = deb_ff;
      if (cls == cand_ff) begin
         if (since_change >= TIME_W'(debounce_ff)) begin
            deb_in = cls;
         end
      end else begin
         change_in = now_ff;
         cand_in   = cls;
      end
      active = deb_in != '0;

      state_in   = state_ff;
      phase_in   = phase_ff;
      latched_in = latched_ff;
      counts_in  = counts_ff;
      seq_end    = 1'b0;
      ev         = EV_NONE;

      case (state_ff)
         ST_IDLE: begin
            if (active) begin
               seq_end    = 1'b1;
               latched_in = deb_in;
            end
         end
         ST_DOWN: begin
            if (!active) begin
               state_in = ST_UP;
               phase_in = now_ff;
            end else if (wait_ms > TIME_W'(long_ff)) begin
               state_in = ST_LONG;
               ev       = EV_LONG_START;
            end
         end
         ST_UP: begin
            state_in = ST_COUNT;
            if (has_btn && counts_ff[idx] != COUNT_MAX) begin
               counts_in[idx] = counts_ff[idx] + COUNT_W'(1);
            end
         end
         ST_COUNT: begin
            if (active) begin
               state_in = ST_DOWN;
               phase_in = now_ff;
            end else if (wait_ms >= TIME_W'(gap_ff) || n == limit_ff) begin
               if (n == COUNT_W'(1)) begin
                  ev = EV_CLICK;
               end else if (n == COUNT_W'(2)) begin
                  ev = EV_DOUBLE;
               end
               seq_end = 1'b1;
            end
         end
         ST_LONG: begin
            if (!active) begin
               state_in = ST_LONG_END;
               phase_in = now_ff;
            end else begin
               ev = EV_LONG_DURING;
            end
         end
         ST_LONG_END: begin
            ev      = EV_LONG_STOP;
            seq_end = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase

      // End of sequence clears counts; a fresh press then starts DOWN
      if (seq_end) begin
         state_in = ST_IDLE;
         phase_in = '0;
         for (int i = 0; i < MAX_BUTTONS; i++) begin
            counts_in[i] = '0;
         end
         if (state_ff == ST_IDLE) begin
            state_in = ST_DOWN;
            phase_in = now_ff;
         end
      end

      if (!has_btn) begin
         ev = EV_NONE;
      end
      code_in   = ev;
      button_in = (ev != EV_NONE) ? latched_ff : '0;
   end

   // State update, one request per advance
   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff    <= '0;
         change_ff  <= '0;
         deb_ff     <= '0;
         state_ff   <= ST_IDLE;
         phase_ff   <= '0;
         latched_ff <= '0;
         for (int i = 0; i < MAX_BUTTONS; i++) begin
            counts_ff[i] <= '0;
         end
      end else if (advance) begin
         cand_ff    <= cand_in;
         change_ff  <= change_in;
         deb_ff     <= deb_in;
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         latched_ff <= latched_in;
         counts_ff  <= counts_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         code_ff   <= code_in;
         button_ff <= button_in;
      end
   end

   // Checks
   a_event_has_button: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && code_ff != EV_NONE) |-> (button_ff != '0))
      else $error("event reported without a button");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while both stages are full");

   a_long_start: assert property (@(posedge clock) disable iff (reset)
      (advance && state_ff == ST_DOWN && state_in == ST_LONG)
      |=> (code_ff == EV_LONG_START))
      else $error("long press entered without a long-start event");

   a_idle_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (counts_ff[0] == '0 && counts_ff[1] == '0 &&
                                 counts_ff[2] == '0 && counts_ff[3] == '0))
      else $error("click counts left over in idle");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(code_ff)))
      else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the resistor-ladder keypad event detector.
`timescale 1ns / 1ps

module testbench;
   import rlbe_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned PHASE_ITEMS    = 75;

   typedef struct packed {
      logic [EVENT_W-1:0] code;
      logic [CLASS_W-1:0] button;
   } keypad_event_type;

   // DUT ports
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [47:0] req_tdata  = '0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [7:0]  rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [19:0]           csr_wdata = '0;

   // Predictor copy of the configuration
   logic [19:0]         cfg_window [MAX_BUTTONS];
   logic [HOLD_W-1:0]   cfg_debounce;
   logic [HOLD_W-1:0]   cfg_gap;
   logic [HOLD_W-1:0]   cfg_long;
   logic [LIMIT_W-1:0]  cfg_limit;

   // Predictor copy of the detector state
   logic [CLASS_W-1:0]  kp_candidate;
   logic [TIME_W-1:0]   kp_change_ms;
   logic [CLASS_W-1:0]  kp_stable;
   logic [STATE_W-1:0]  kp_state;
   logic [TIME_W-1:0]   kp_phase_ms;
   logic [CLASS_W-1:0]  kp_latched;
   logic [COUNT_W-1:0]  kp_clicks [MAX_BUTTONS];

   keypad_event_type expected_events[$];
   int unsigned   mismatch_count = 0;
   int unsigned   quiet_cycles   = 0;
   int unsigned   items_sent     = 0;
   int unsigned   send_idle_pct  = 0;
   int unsigned   recv_idle_pct  = 0;
   logic [TIME_W-1:0] now_ms     = '0;
   logic [19:0]   reg_plan [8];

   resistor_ladder_button_events_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   // Lowest-numbered matching window wins; inverted windows never match
   function automatic logic [CLASS_W-1:0] classify_adc(input logic [9:0] adc_value);
      logic [CLASS_W-1:0] cls;
      cls = '0;
      for (int b = MAX_BUTTONS - 1; b >= 0; b--) begin
         if (adc_value >= cfg_window[b][9:0] && adc_value <= cfg_window[b][19:10])
            cls = b[2:0] + 3'd1;
      end
      return cls;
   endfunction

   function automatic void end_gesture();
      kp_state    = ST_IDLE;
      kp_phase_ms = '0;
      for (int i = 0; i < MAX_BUTTONS; i++) kp_clicks[i] = '0;
   endfunction

   function automatic void reset_keypad_model();
      cfg_window[0] = 20'd102400;   // 0..100
      cfg_window[1] = 20'd307350;   // 150..300
      cfg_window[2] = 20'd563550;   // 350..550
      cfg_window[3] = 20'd819800;   // 600..800
      cfg_debounce  = DEBOUNCE_RST;
      cfg_gap       = GAP_RST;
      cfg_long      = LONG_RST;
      cfg_limit     = LIMIT_RST;
      kp_candidate  = '0;
      kp_change_ms  = '0;
      kp_stable     = '0;
      kp_latched    = '0;
      end_gesture();
   endfunction

   function automatic void apply_register(input logic [CSR_ADDR_W-1:0] addr,
                                          input logic [19:0] value);
      case (addr)
         REG_RANGE1:   cfg_window[0] = value;
         REG_RANGE2:   cfg_window[1] = value;
         REG_RANGE3:   cfg_window[2] = value;
         REG_RANGE4:   cfg_window[3] = value;
         REG_DEBOUNCE: cfg_debounce  = value[15:0];
         REG_GAP:      cfg_gap       = value[15:0];
         REG_LONG:     cfg_long      = value[15:0];
         REG_LIMIT:    cfg_limit     = value[1:0];
         default: ;
      endcase
   endfunction

   // One sample in, one event out; updates the predictor state
   function automatic keypad_event_type keypad_step(input logic [9:0] adc_value,
                                                    input logic [TIME_W-1:0] stamp);
      logic [CLASS_W-1:0] cls;
      logic [EVENT_W-1:0] ev;
      logic [TIME_W-1:0]  waited;
      logic               active;
      logic               has_btn;
      logic [1:0]         idx;
      logic [COUNT_W-1:0] n;
      keypad_event_type   res;
      cls     = classify_adc(adc_value);
      ev      = EV_NONE;
      has_btn = (kp_latched >= 3'd1) && (kp_latched <= 3'd4);
      idx     = has_btn ? kp_latched[1:0] - 2'd1 : 2'd0;

      // Debounce, then the machine sees the new level in the same step
      if (cls == kp_candidate) begin
         if (stamp - kp_change_ms >= {16'd0, cfg_debounce}) kp_stable = cls;
      end else begin
         kp_change_ms = stamp;
         kp_candidate = cls;
      end
      active = kp_stable != '0;
      waited = stamp - kp_phase_ms;

      case (kp_state)
         ST_IDLE: begin
            if (active) begin
               end_gesture();
               kp_state    = ST_DOWN;
               kp_phase_ms = stamp;
               kp_latched  = kp_stable;
            end
         end
         ST_DOWN: begin
            if (!active) begin
               kp_state    = ST_UP;
               kp_phase_ms = stamp;
            end else if (waited > {16'd0, cfg_long}) begin
               kp_state = ST_LONG;
               ev       = EV_LONG_START;
            end
         end
         ST_UP: begin
            kp_state = ST_COUNT;
            if (has_btn && kp_clicks[idx] != COUNT_MAX) kp_clicks[idx] = kp_clicks[idx] + 2'd1;
         end
         ST_COUNT: begin
            if (active) begin
               kp_state    = ST_DOWN;
               kp_phase_ms = stamp;
            end else begin
               n = has_btn ? kp_clicks[idx] : '0;
               if (waited >= {16'd0, cfg_gap} || n == cfg_limit) begin
                  if (n == 2'd1) ev = EV_CLICK;
                  else if (n == 2'd2) ev = EV_DOUBLE;
                  end_gesture();
               end
            end
         end
         ST_LONG: begin
            if (!active) begin
               kp_state    = ST_LONG_END;
               kp_phase_ms = stamp;
            end else begin
               ev = EV_LONG_DURING;
            end
         end
         ST_LONG_END: begin
            ev = EV_LONG_STOP;
            end_gesture();
         end
         default: kp_state = ST_IDLE;
      endcase

      if (ev != EV_NONE && !has_btn) ev = EV_NONE;
      res.code   = ev;
      res.button = (ev != EV_NONE) ? kp_latched : '0;
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Monitor, scoreboard and watchdog
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      keypad_event_type want;
      keypad_event_type got;
      if (reset) begin
         reset_keypad_model();
         quiet_cycles <= 0;
      end else begin
         if (csr_we) apply_register(csr_addr, csr_wdata);
         if (req_tvalid && req_tready)
            expected_events.push_back(keypad_step(req_tdata[9:0], req_tdata[41:10]));
         if (rsp_tvalid && rsp_tready) begin
            got.code   = rsp_tdata[2:0];
            got.button = rsp_tdata[5:3];
            if (expected_events.size() == 0) begin
               $display("%0t: unexpected event: actual code %0d button %0d",
                        $time, got.code, got.button);
               mismatch_count++;
            end else begin
               want = expected_events.pop_front();
               if (got.code != want.code) begin
                  $display("%0t: event code mismatch: expected %0d, actual %0d",
                           $time, want.code, got.code);
                  mismatch_count++;
               end
               if (got.button != want.button) begin
                  $display("%0t: event button mismatch: expected %0d, actual %0d",
                           $time, want.button, got.button);
                  mismatch_count++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            quiet_cycles <= 0;
         else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d events outstanding",
                     $time, expected_events.size());
            $display("testbench: done, errors");
            $finish;
         end else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Event sink with random back-pressure
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------

   // Send one request; returns with tvalid still high after acceptance
   task automatic send_sample(input logic [9:0] adc_value, input logic [TIME_W-1:0] stamp);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, stamp, adc_value};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Stop sending and wait until every expected event has come back
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all eight registers from reg_plan
   task automatic program_registers();
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= i[2:0];
         csr_wdata <= reg_plan[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [9:0] pick_in_window(input int unsigned btn);
      logic [9:0] lo;
      logic [9:0] hi;
      lo = cfg_window[btn-1][9:0];
      hi = cfg_window[btn-1][19:10];
      if (lo <= hi) return 10'($urandom_range(lo, hi));
      return 10'($urandom_range(0, 1023));
   endfunction

   function automatic logic [9:0] pick_released();
      logic [9:0] v;
      v = 10'($urandom_range(0, 1023));
      for (int i = 0; i < 8 && classify_adc(v) != '0; i++) v = 10'($urandom_range(0, 1023));
      return v;
   endfunction

   // Hold one level (btn 0 = released) for about span_ms
   task automatic hold_level(input int unsigned btn, input int unsigned span_ms);
      int unsigned stride;
      int unsigned elapsed;
      int unsigned sent;
      stride  = span_ms / $urandom_range(2, 6);
      if (stride == 0) stride = 1;
      elapsed = 0;
      sent    = 0;
      while (elapsed < span_ms || sent < 2) begin
         now_ms  += stride;
         elapsed += stride;
         send_sample(btn == 0 ? pick_released() : pick_in_window(btn), now_ms);
         sent++;
      end
   endtask

   // One random gesture: clicks and holds, noise, or contact bounce
   task automatic run_gesture();
      int unsigned pick;
      int unsigned btn;
      int unsigned clicks;
      int unsigned deb;
      int unsigned span;
      int unsigned bounces;
      pick = $urandom_range(0, 99);
      btn  = $urandom_range(1, 4);
      deb  = cfg_debounce;
      if (pick < 75) begin
         clicks = $urandom_range(1, 4);
         repeat (clicks) begin
            if ($urandom_range(0, 3) == 0)
               span = 2 * deb + cfg_long + $urandom_range(1, cfg_long / 2 + 4);
            else
               span = 2 * deb + $urandom_range(0, cfg_long / 2);
            hold_level(btn, span);
            if ($urandom_range(0, 1) == 0)
               span = 2 * deb + $urandom_range(0, cfg_gap / 2);
            else
               span = 2 * deb + cfg_gap + $urandom_range(1, cfg_gap / 2 + 4);
            hold_level(0, span);
         end
      end else if (pick < 88) begin
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 7) == 0) now_ms += $urandom;
            else now_ms += $urandom_range(0, deb + cfg_gap + 2);
            send_sample(10'($urandom_range(0, 1023)), now_ms);
         end
      end else begin
         bounces = $urandom_range(4, 12);
         for (int i = 0; i < bounces; i++) begin
            now_ms += $urandom_range(0, deb / 2 + 1);
            send_sample(i[0] ? pick_released() : pick_in_window(btn), now_ms);
         end
      end
   endtask

   // Pick a register setting: small, all zero, all ones, or raw random
   task automatic configure(input int unsigned kind);
      wait_drain();
      for (int b = 0; b < 4; b++) begin
         case (kind)
            0: reg_plan[b] = {10'(b * 256 + $urandom_range(150, 250)),
                              10'(b * 256 + $urandom_range(0, 60))};
            1: reg_plan[b] = 20'h00000;
            2: reg_plan[b] = 20'hFFFFF;
            default: reg_plan[b] = 20'($urandom);
         endcase
      end
      case (kind)
         0: begin
            reg_plan[REG_DEBOUNCE] = 20'($urandom_range(0, 8));
            reg_plan[REG_GAP]      = 20'($urandom_range(3, 40));
            reg_plan[REG_LONG]     = 20'($urandom_range(5, 60));
            reg_plan[REG_LIMIT]    = 20'($urandom_range(1, 2));
         end
         1: for (int i = 4; i < 8; i++) reg_plan[i] = 20'h00000;
         2: for (int i = 4; i < 8; i++) reg_plan[i] = 20'hFFFFF;
         default: for (int i = 4; i < 8; i++) reg_plan[i] = 20'($urandom);
      endcase
      program_registers();
      now_ms = $urandom_range(0, 1) ? 32'($urandom) : 32'hFFFF_FFFF - $urandom_range(0, 2000);
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Reset windows and timings: a single click, then a long press
   task automatic test_default_click_and_long();
      send_sample(10'd1023, 32'd0);
      send_sample(10'd0,    32'd0);
      send_sample(10'd0,    32'd50);
      send_sample(10'd1023, 32'd100);
      send_sample(10'd1023, 32'd150);
      send_sample(10'd1023, 32'd151);
      send_sample(10'd1023, 32'd152);
      send_sample(10'd200,  32'd1000);
      send_sample(10'd200,  32'd1050);
      send_sample(10'd200,  32'd1851);
      send_sample(10'd200,  32'd1900);
      send_sample(10'd1023, 32'd1950);
      send_sample(10'd1023, 32'd2000);
      send_sample(10'd1023, 32'hFFFF_FFFF);
   endtask

   // Overlapping and inverted windows, zero debounce, count resolving at three
   task automatic test_overlap_and_click_limit();
      wait_drain();
      reg_plan[REG_RANGE1]   = {10'd500, 10'd0};
      reg_plan[REG_RANGE2]   = {10'd600, 10'd400};   // overlaps button 1
      reg_plan[REG_RANGE3]   = {10'd800, 10'd900};   // inverted, never matches
      reg_plan[REG_RANGE4]   = {10'd700, 10'd601};
      reg_plan[REG_DEBOUNCE] = 20'd0;
      reg_plan[REG_GAP]      = 20'd20;
      reg_plan[REG_LONG]     = 20'd1000;
      reg_plan[REG_LIMIT]    = 20'd3;
      program_registers();
      now_ms = 32'd10;
      repeat (3) begin
         repeat (2) begin
            send_sample(10'd450, now_ms);
            now_ms++;
         end
         repeat (3) begin
            send_sample(10'd850, now_ms);
            now_ms++;
         end
      end
      send_sample(10'd850, now_ms);
   endtask

   task automatic test_random_traffic(input int unsigned phase,
                                      input int unsigned send_pct,
                                      input int unsigned recv_pct);
      int unsigned target;
      for (int unsigned sub = 0; sub < 3; sub++) begin
         configure((phase * 3 + sub) % 4);
         send_idle_pct = send_pct;
         recv_idle_pct = recv_pct;
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) run_gesture();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_click_and_long();
      test_overlap_and_click_limit();
      test_random_traffic(0, 13, 73);
      test_random_traffic(1, 73, 13);
      test_random_traffic(2, 0, 0);

      wait_drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_events.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
